[hdl/pecu_pkg.sv]
// ----------------------------------------------------------------------------
// pecu_pkg: shared types and constants for the projectile end check unit
// Verdict codes, register map, fixed widths, divider depth and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pecu_pkg;

	// Field widths
	localparam int CRD_W = 32;
	localparam int REACH_W = 63;
	localparam int WIDE_W = 64;
	localparam int PRD_W = 96;

	// Default saturation width for corrected coordinates
	localparam int COORD_BITS_DEF = 32;

	// Quotient bits kept by the divider; larger moves saturate at the cap
	localparam int DIV_STEPS = 41;
	localparam logic [DIV_STEPS-1:0] DELTA_CAP = DIV_STEPS'(1) << (DIV_STEPS - 1);

	// Queue between classifier and mover
	localparam int QUEUE_DEPTH = 4;

	// Verdict codes
	localparam logic [1:0] VERDICT_FLYING = 2'd0;
	localparam logic [1:0] VERDICT_GROUND = 2'd1;
	localparam logic [1:0] VERDICT_CORRECTED = 2'd2;
	localparam logic [1:0] VERDICT_ZERO_SPEED = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_SHOOTER_X = 3'd0;
	localparam logic [2:0] REG_SHOOTER_Z = 3'd1;
	localparam logic [2:0] REG_TARGET_X = 3'd2;
	localparam logic [2:0] REG_TARGET_Z = 3'd3;
	localparam logic [2:0] REG_REACH_SQ = 3'd4;

	typedef struct packed {
		logic signed [CRD_W-1:0] shooter_x;
		logic signed [CRD_W-1:0] shooter_z;
		logic signed [CRD_W-1:0] target_x;
		logic signed [CRD_W-1:0] target_z;
		logic [REACH_W-1:0] reach_sq;
	} cfg_t;

	// Classified request handed from the front to the mover
	typedef struct packed {
		logic [1:0] verdict;
		logic signed [CRD_W-1:0] pos_x;
		logic signed [CRD_W-1:0] pos_y;
		logic signed [CRD_W-1:0] pos_z;
		logic signed [CRD_W-1:0] vel_x;
		logic signed [CRD_W-1:0] vel_y;
		logic signed [CRD_W-1:0] vel_z;
		logic [WIDE_W-1:0] num;
		logic nneg;
		logic [WIDE_W-1:0] den;
	} item_t;

	function automatic logic [CRD_W:0] mag33(input logic signed [CRD_W:0] v);
		logic signed [CRD_W:0] n;
		n = -v;
		return v[CRD_W] ? n : v;
	endfunction

	function automatic logic [CRD_W-1:0] mag32(input logic signed [CRD_W-1:0] v);
		logic signed [CRD_W-1:0] n;
		n = -v;
		return v[CRD_W-1] ? n : v;
	endfunction

endpackage

`default_nettype wire

[hdl/pecu_in_if.sv]
// ----------------------------------------------------------------------------
// pecu_in_if: projectile request channel
// Valid/ready handshake carrying position and velocity.
// ----------------------------------------------------------------------------
`default_nettype none

interface pecu_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;

	modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

`default_nettype wire

[hdl/pecu_out_if.sv]
// ----------------------------------------------------------------------------
// pecu_out_if: verdict channel
// Valid/ready handshake carrying verdict and resulting position.
// ----------------------------------------------------------------------------
`default_nettype none

interface pecu_out_if;
	logic valid;
	logic ready;
	logic [1:0] verdict;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;

	modport source(output valid, verdict, out_x, out_y, out_z, input ready);
	modport sink(input valid, verdict, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

[hdl/pecu_front.sv]
// ----------------------------------------------------------------------------
// pecu_front: request classifier
// Two register stages: differences and magnitudes, then squares and dot
// products; the verdict, |v|^2 and signed dot product go to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pecu_front (
	input wire clk,
	input wire arst_n,
	input wire pecu_pkg::cfg_t cfg,
	pecu_in_if.sink in,
	output pecu_pkg::item_t push_item,
	output logic push_valid,
	input wire full
);
	import pecu_pkg::*;

	logic adv;
	logic v_s1, v_s2;

	// Stage 1 payload
	logic signed [CRD_W-1:0] px_s1, py_s1, pz_s1, vx_s1, vy_s1, vz_s1;
	logic [CRD_W:0] ax_s1, az_s1, atx_s1, atz_s1;
	logic ntx_s1, ntz_s1;
	logic [CRD_W-1:0] avx_s1, avz_s1;

	// Stage 2 payload
	logic signed [CRD_W-1:0] px_s2, py_s2, pz_s2, vx_s2, vy_s2, vz_s2;
	logic [WIDE_W-1:0] sqx_s2, sqz_s2, vx2_s2, vz2_s2, mx_s2, mz_s2;
	logic nx_s2, nz_s2;

	logic signed [CRD_W:0] dx, dz, tx, tz;
	logic [2*CRD_W+1:0] sqx_p, sqz_p;
	logic [2*CRD_W:0] mx_p, mz_p;
	logic [WIDE_W-1:0] reach_left, den, num;
	logic over, ground, nneg;

	// Stall the whole front while the queue is full and stage 2 holds a request
	assign adv = !v_s2 || !full;
	assign in.ready = adv;

	assign dx = {in.pos_x[CRD_W-1], in.pos_x} - {cfg.shooter_x[CRD_W-1], cfg.shooter_x};
	assign dz = {in.pos_z[CRD_W-1], in.pos_z} - {cfg.shooter_z[CRD_W-1], cfg.shooter_z};
	assign tx = {cfg.target_x[CRD_W-1], cfg.target_x} - {in.pos_x[CRD_W-1], in.pos_x};
	assign tz = {cfg.target_z[CRD_W-1], cfg.target_z} - {in.pos_z[CRD_W-1], in.pos_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in.valid;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: offsets from shooter and target, magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= in.pos_x;
			py_s1 <= in.pos_y;
			pz_s1 <= in.pos_z;
			vx_s1 <= in.vel_x;
			vy_s1 <= in.vel_y;
			vz_s1 <= in.vel_z;
			ax_s1 <= mag33(dx);
			az_s1 <= mag33(dz);
			atx_s1 <= mag33(tx);
			atz_s1 <= mag33(tz);
			ntx_s1 <= tx[CRD_W];
			ntz_s1 <= tz[CRD_W];
			avx_s1 <= mag32(in.vel_x);
			avz_s1 <= mag32(in.vel_z);
		end
	end

	assign sqx_p = ax_s1 * ax_s1;
	assign sqz_p = az_s1 * az_s1;
	assign mx_p = atx_s1 * avx_s1;
	assign mz_p = atz_s1 * avz_s1;

	// Stage 2: squares and dot product terms
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			pz_s2 <= pz_s1;
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
			vz_s2 <= vz_s1;
			sqx_s2 <= sqx_p[WIDE_W-1:0];
			sqz_s2 <= sqz_p[WIDE_W-1:0];
			vx2_s2 <= avx_s1 * avx_s1;
			vz2_s2 <= avz_s1 * avz_s1;
			mx_s2 <= mx_p[WIDE_W-1:0];
			mz_s2 <= mz_p[WIDE_W-1:0];
			nx_s2 <= ntx_s1 ^ vx_s1[CRD_W-1];
			nz_s2 <= ntz_s1 ^ vz_s1[CRD_W-1];
		end
	end

	// Classify and combine signed dot product terms
	always_comb begin
		reach_left = {1'b0, cfg.reach_sq} - sqx_s2;
		over = (sqx_s2 > {1'b0, cfg.reach_sq}) || (sqz_s2 > reach_left);
		den = vx2_s2 + vz2_s2;
		ground = (py_s2 <= 0);
		if (mx_s2 == '0) begin
			num = mz_s2;
			nneg = nz_s2;
		end else if (mz_s2 == '0) begin
			num = mx_s2;
			nneg = nx_s2;
		end else if (nx_s2 == nz_s2) begin
			num = mx_s2 + mz_s2;
			nneg = nx_s2;
		end else if (mx_s2 >= mz_s2) begin
			num = mx_s2 - mz_s2;
			nneg = nx_s2;
		end else begin
			num = mz_s2 - mx_s2;
			nneg = nz_s2;
		end
		if (ground) begin
			push_item.verdict = VERDICT_GROUND;
		end else if (!over) begin
			push_item.verdict = VERDICT_FLYING;
		end else if (den == '0) begin
			push_item.verdict = VERDICT_ZERO_SPEED;
		end else begin
			push_item.verdict = VERDICT_CORRECTED;
		end
		push_item.pos_x = px_s2;
		push_item.pos_y = py_s2;
		push_item.pos_z = pz_s2;
		push_item.vel_x = vx_s2;
		push_item.vel_y = vy_s2;
		push_item.vel_z = vz_s2;
		push_item.num = num;
		push_item.nneg = nneg;
		push_item.den = den;
	end

	assign push_valid = v_s2;

endmodule

`default_nettype wire

[hdl/pecu_queue.sv]
// ----------------------------------------------------------------------------
// pecu_queue: request queue between classifier and mover
// Small register queue that lets each side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module pecu_queue (
	input wire clk,
	input wire arst_n,
	input wire pecu_pkg::item_t wr_item,
	input wire wr_valid,
	output logic full,
	output pecu_pkg::item_t rd_item,
	output logic empty,
	input wire rd_take
);
	import pecu_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [PTR_W:0] cnt_q;
	logic push, pop;

	assign full = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign push = wr_valid && !full;
	assign pop = rd_take && !empty;
	assign rd_item = ent_q[rp_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

[hdl/pecu_div.sv]
// ----------------------------------------------------------------------------
// pecu_div: pipelined restoring divider
// One quotient bit per stage, most significant first, from a partial
// remainder already below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pecu_div (
	input wire clk,
	input wire en,
	input wire [pecu_pkg::WIDE_W-1:0] den,
	input wire [pecu_pkg::WIDE_W-1:0] rem0,
	input wire [pecu_pkg::DIV_STEPS-1:0] low,
	output logic [pecu_pkg::DIV_STEPS-1:0] quot
);
	import pecu_pkg::*;

	logic [WIDE_W-1:0] rem_q [1:DIV_STEPS];
	logic [WIDE_W-1:0] den_q [1:DIV_STEPS];
	logic [DIV_STEPS-1:0] low_q [1:DIV_STEPS];
	logic [DIV_STEPS-1:0] quot_q [1:DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [WIDE_W-1:0] rem_i, den_i;
		logic [DIV_STEPS-1:0] low_i, quot_i;
		logic [WIDE_W:0] trial, diff;
		logic take;

		if (k == 0) begin : g_head
			assign rem_i = rem0;
			assign den_i = den;
			assign low_i = low;
			assign quot_i = '0;
		end else begin : g_tail
			assign rem_i = rem_q[k];
			assign den_i = den_q[k];
			assign low_i = low_q[k];
			assign quot_i = quot_q[k];
		end

		// Bring down the next dividend bit and try the subtract
		assign trial = {rem_i, low_i[DIV_STEPS-1-k]};
		assign diff = trial - {1'b0, den_i};
		assign take = (trial >= {1'b0, den_i});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= take ? diff[WIDE_W-1:0] : trial[WIDE_W-1:0];
				den_q[k+1] <= den_i;
				low_q[k+1] <= low_i;
				quot_q[k+1] <= {quot_i[DIV_STEPS-2:0], take};
			end
		end
	end

	assign quot = quot_q[DIV_STEPS];

endmodule

`default_nettype wire

[hdl/pecu_back.sv]
// ----------------------------------------------------------------------------
// pecu_back: position mover
// Scales each velocity component by the dot product, divides by |v|^2,
// applies the signed move with saturation to corrected requests and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pecu_back #(
	parameter int COORD_BITS = pecu_pkg::COORD_BITS_DEF
) (
	input wire clk,
	input wire arst_n,
	input wire pecu_pkg::item_t rd_item,
	input wire empty,
	output logic rd_take,
	pecu_out_if.source out
);
	import pecu_pkg::*;

	localparam int SUM_W = DIV_STEPS + 2;
	localparam logic signed [SUM_W-1:0] SAT_HI =
		SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	typedef struct packed {
		logic [1:0] verdict;
		logic [2:0][CRD_W-1:0] pos;
		logic [2:0] neg;
		logic [2:0] big;
	} side_t;

	logic adv;
	logic v_s1, v_s2, v_s3;
	side_t side_s1, side_s2, side_s3;
	logic [2:0][WIDE_W-1:0] plo_s1, phi_s1;
	logic [WIDE_W-1:0] den_s1, den_s2, den_s3;
	logic [2:0][PRD_W-1:0] prd_s2;
	logic [2:0][WIDE_W-1:0] rem_s3;
	logic [2:0][DIV_STEPS-1:0] low_s3;

	logic vd_q [1:DIV_STEPS];
	side_t sd_q [1:DIV_STEPS];
	logic [2:0][DIV_STEPS-1:0] quot;

	logic [2:0][CRD_W-1:0] vel_in, mv;
	logic [2:0][CRD_W-1:0] res;
	logic vo_q;
	logic [1:0] verdict_q;
	logic [2:0][CRD_W-1:0] res_q;

	// Stall every stage while the output register holds an untaken result
	assign adv = !vo_q || out.ready;
	assign rd_take = adv;

	assign vel_in[0] = rd_item.vel_x;
	assign vel_in[1] = rd_item.vel_y;
	assign vel_in[2] = rd_item.vel_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mv[i] = mag32(vel_in[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: partial products of |v| with the dot product halves
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.verdict <= rd_item.verdict;
			side_s1.pos[0] <= rd_item.pos_x;
			side_s1.pos[1] <= rd_item.pos_y;
			side_s1.pos[2] <= rd_item.pos_z;
			side_s1.big <= '0;
			den_s1 <= rd_item.den;
			for (int i = 0; i < 3; i++) begin
				side_s1.neg[i] <= vel_in[i][CRD_W-1] ^ rd_item.nneg;
				plo_s1[i] <= mv[i] * rd_item.num[CRD_W-1:0];
				phi_s1[i] <= mv[i] * rd_item.num[WIDE_W-1:CRD_W];
			end
		end
	end

	// Stage 2: full dividend
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			den_s2 <= den_s1;
			for (int i = 0; i < 3; i++) begin
				prd_s2[i] <= {32'b0, plo_s1[i]} + {phi_s1[i], 32'b0};
			end
		end
	end

	// Stage 3: flag quotients past the kept bits, seed the remainder
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.verdict <= side_s2.verdict;
			side_s3.pos <= side_s2.pos;
			side_s3.neg <= side_s2.neg;
			den_s3 <= den_s2;
			for (int i = 0; i < 3; i++) begin
				side_s3.big[i] <= ({9'b0, prd_s2[i][PRD_W-1:DIV_STEPS]} >= den_s2);
				rem_s3[i] <= {9'b0, prd_s2[i][PRD_W-1:DIV_STEPS]};
				low_s3[i] <= prd_s2[i][DIV_STEPS-1:0];
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_lane
		pecu_div u_div (
			.clk(clk),
			.en(adv),
			.den(den_s3),
			.rem0(rem_s3[c]),
			.low(low_s3[c]),
			.quot(quot[c])
		);
	end

	// Carry valid and side data alongside the divider stages
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_q[k] <= 1'b0;
			end else if (adv) begin
				if (k == 1) begin
					vd_q[k] <= v_s3;
				end else begin
					vd_q[k] <= vd_q[(k > 1) ? k - 1 : 1];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (k == 1) begin
					sd_q[k] <= side_s3;
				end else begin
					sd_q[k] <= sd_q[(k > 1) ? k - 1 : 1];
				end
			end
		end
	end

	// Cap, sign and saturate the move; keep the position otherwise
	always_comb begin
		logic [DIV_STEPS-1:0] qc;
		logic signed [SUM_W-1:0] dv, sum;
		for (int i = 0; i < 3; i++) begin
			qc = (sd_q[DIV_STEPS].big[i] || quot[i] > DELTA_CAP) ? DELTA_CAP : quot[i];
			dv = {2'b0, qc};
			if (sd_q[DIV_STEPS].neg[i]) begin
				dv = -dv;
			end
			sum = {{(SUM_W-CRD_W){sd_q[DIV_STEPS].pos[i][CRD_W-1]}},
				sd_q[DIV_STEPS].pos[i]} + dv;
			if (sum > SAT_HI) begin
				sum = SAT_HI;
			end else if (sum < SAT_LO) begin
				sum = SAT_LO;
			end
			if (sd_q[DIV_STEPS].verdict == VERDICT_CORRECTED) begin
				res[i] = sum[CRD_W-1:0];
			end else begin
				res[i] = sd_q[DIV_STEPS].pos[i];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (adv) begin
			vo_q <= vd_q[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			verdict_q <= sd_q[DIV_STEPS].verdict;
			res_q <= res;
		end
	end

	assign out.valid = vo_q;
	assign out.verdict = verdict_q;
	assign out.out_x = res_q[0];
	assign out.out_y = res_q[1];
	assign out.out_z = res_q[2];

endmodule

`default_nettype wire

[hdl/projectile_end_check_unit.sv]
// Projectile end check. Takes one request per clock unless the output stalls
// and returns one verdict per request, in order: two classifier stages feed a
// four-entry queue, and the mover spends three stages on the 32x32 partial
// products, the dividend and the remainder seed, 41 stages in the pipelined
// restoring divider (one quotient bit each) and one output stage. Sustained
// rate is one request per cycle without output stalls. Registers sit at byte
// addresses 0, 8, 16, 24, 32 on a 64-bit APB port and should be written while idle.
// ----------------------------------------------------------------------------
// projectile_end_check_unit: top level
// Register file, classifier, queue and mover.
// ----------------------------------------------------------------------------
`default_nettype none

module projectile_end_check_unit #(
	parameter int COORD_BITS = pecu_pkg::COORD_BITS_DEF
) (
	input wire clk,
	input wire arst_n,
	pecu_in_if.sink in,
	pecu_out_if.source out,
	input wire psel,
	input wire penable,
	input wire pwrite,
	input wire [5:0] paddr,
	input wire [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	import pecu_pkg::*;

	cfg_t cfg_q;
	item_t push_item, rd_item;
	logic push_valid, full, empty, rd_take;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_SHOOTER_X: cfg_q.shooter_x <= pwdata[CRD_W-1:0];
				REG_SHOOTER_Z: cfg_q.shooter_z <= pwdata[CRD_W-1:0];
				REG_TARGET_X: cfg_q.target_x <= pwdata[CRD_W-1:0];
				REG_TARGET_Z: cfg_q.target_z <= pwdata[CRD_W-1:0];
				REG_REACH_SQ: cfg_q.reach_sq <= pwdata[REACH_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			REG_SHOOTER_X: prdata = {{32{cfg_q.shooter_x[CRD_W-1]}}, cfg_q.shooter_x};
			REG_SHOOTER_Z: prdata = {{32{cfg_q.shooter_z[CRD_W-1]}}, cfg_q.shooter_z};
			REG_TARGET_X: prdata = {{32{cfg_q.target_x[CRD_W-1]}}, cfg_q.target_x};
			REG_TARGET_Z: prdata = {{32{cfg_q.target_z[CRD_W-1]}}, cfg_q.target_z};
			REG_REACH_SQ: prdata = {1'b0, cfg_q.reach_sq};
			default: prdata = '0;
		endcase
	end

	pecu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in(in),
		.push_item(push_item),
		.push_valid(push_valid),
		.full(full)
	);

	pecu_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_item(push_item),
		.wr_valid(push_valid),
		.full(full),
		.rd_item(rd_item),
		.empty(empty),
		.rd_take(rd_take)
	);

	pecu_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rd_item(rd_item),
		.empty(empty),
		.rd_take(rd_take),
		.out(out)
	);

endmodule

`default_nettype wire
